// ----- design/point_in_chamber_volume_test_defines.svh -----
// Assertion macros for the checker file of the chamber volume test.
// Each macro samples on the rising edge of aclk and is off while aresetn is low.
`ifndef POINT_IN_CHAMBER_VOLUME_TEST_DEFINES_SVH
`define POINT_IN_CHAMBER_VOLUME_TEST_DEFINES_SVH

// Condition holds at every sampled edge.
`define PICVT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Consequent holds at the same edge as the antecedent.
`define PICVT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds at the edge after the antecedent.
`define PICVT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/picvt_pkg.sv -----
package picvt_pkg;

    // Fixed geometry in micrometres
    localparam int EXIT_CYL_RADIUS = 3000;
    localparam int CONE_LENGTH     = 3000;
    localparam int NOZZLE_EXTRA    = 500;
    localparam int WINDOW_RADIUS   = 2000;
    localparam int RIM_OFFSET      = 1500;

    // cos and sin of 50 degrees with 30 fraction bits
    localparam int COS50_Q30 = 690187940;
    localparam int SIN50_Q30 = 822533958;

    // Configuration register widths and reset values
    localparam int CHAMBER_RADIUS_W  = 14;
    localparam int CYLINDER_HEIGHT_W = 15;
    localparam int EXIT_RADIUS_W     = 12;
    localparam int CFG_DATA_W        = 15;
    localparam int CFG_INDEX_W       = 2;

    localparam logic [CHAMBER_RADIUS_W-1:0]  CHAMBER_RADIUS_RST  = 14'd8000;
    localparam logic [CYLINDER_HEIGHT_W-1:0] CYLINDER_HEIGHT_RST = 15'd8000;
    localparam logic [EXIT_RADIUS_W-1:0]     EXIT_RADIUS_RST     = 12'd750;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CHAMBER_RADIUS  = 2'd0,
        REG_CYLINDER_HEIGHT = 2'd1,
        REG_EXIT_RADIUS     = 2'd2
    } cfg_reg_t;

    // Load strobes of the first two pipeline stages
    typedef struct packed {
        logic ld1;
        logic ld2;
    } adv_t;

endpackage

// ----- design/point_in_chamber_volume_test.sv -----
// Point in chamber volume test.
// Slave stream s_*: one word per point, three signed coordinates in micrometres.
// Master stream m_*: one word per point, bit 0 set when the point lies in the
// union of sphere, lower cylinder, exit cylinder, cone, nozzle and laser window.
// The cfg_* port writes chamber radius, cylinder height and exit radius; write
// it only while no word is in flight.
// Four register stages lie between the input handshake and m_tvalid (squares
// and rotation products, sums and rounding, compares and window square, final
// compare and merge). Throughput: one point per cycle while m_tready stays high,
// since every stage then takes a new word each cycle.
// Each stage holds its word only while the stage after it is full and stalled,
// so empty stages keep filling while m_tready is low; s_tready drops once all
// four stages are full.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register
// defaults: radius 8000, height 8000, exit radius 750.
module point_in_chamber_volume_test #(
    parameter int COORD_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata fields, lowest bit up: coord_x, coord_y, coord_z
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // m_tdata fields, lowest bit up: inside_res
    output logic [7:0]                          m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [picvt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [picvt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int C  = COORD_BITS;
    localparam int ZW = ((C > 17) ? C : 17) + 1;          // signed compare width on z and y
    localparam int SW = (2*C + 2 > 30) ? 2*C + 2 : 30;     // width of square compares

    localparam logic [SW-1:0] EXIT_SQ =
        SW'(picvt_pkg::EXIT_CYL_RADIUS * picvt_pkg::EXIT_CYL_RADIUS);
    localparam logic [SW-1:0] WINDOW_SQ =
        SW'(picvt_pkg::WINDOW_RADIUS * picvt_pkg::WINDOW_RADIUS);

    // ---------------------------------------------------------------------
    // Configuration registers and their squares
    // ---------------------------------------------------------------------
    logic [picvt_pkg::CHAMBER_RADIUS_W-1:0]  radius_reg;
    logic [picvt_pkg::CYLINDER_HEIGHT_W-1:0] height_reg;
    logic [picvt_pkg::EXIT_RADIUS_W-1:0]     exit_reg;
    logic [2*picvt_pkg::CHAMBER_RADIUS_W-1:0] rr_reg;
    logic [2*picvt_pkg::EXIT_RADIUS_W-1:0]    ee_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= picvt_pkg::CHAMBER_RADIUS_RST;
            height_reg <= picvt_pkg::CYLINDER_HEIGHT_RST;
            exit_reg   <= picvt_pkg::EXIT_RADIUS_RST;
            rr_reg     <= 28'(picvt_pkg::CHAMBER_RADIUS_RST)
                          * 28'(picvt_pkg::CHAMBER_RADIUS_RST);
            ee_reg     <= 24'(picvt_pkg::EXIT_RADIUS_RST) * 24'(picvt_pkg::EXIT_RADIUS_RST);
        end else begin
            // Squares follow in the next cycle; the user keeps the block idle, unenforced
            rr_reg <= radius_reg * radius_reg;
            ee_reg <= exit_reg * exit_reg;
            if (cfg_wr_en) begin
                case (picvt_pkg::cfg_reg_t'(cfg_index))
                    picvt_pkg::REG_CHAMBER_RADIUS: begin
                        radius_reg <= cfg_wdata[picvt_pkg::CHAMBER_RADIUS_W-1:0];
                    end
                    picvt_pkg::REG_CYLINDER_HEIGHT: begin
                        height_reg <= cfg_wdata[picvt_pkg::CYLINDER_HEIGHT_W-1:0];
                    end
                    picvt_pkg::REG_EXIT_RADIUS: begin
                        exit_reg <= cfg_wdata[picvt_pkg::EXIT_RADIUS_W-1:0];
                    end
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end
        end
    end

    // Derived limits: rim K = R + 1500, cone end K + 3000 - E, nozzle end + 500
    logic [14:0] rim_k;
    logic [15:0] cone_hi, noz_hi;
    assign rim_k   = {1'b0, radius_reg} + 15'(picvt_pkg::RIM_OFFSET);
    assign cone_hi = {1'b0, rim_k} + 16'(picvt_pkg::CONE_LENGTH) - {4'b0, exit_reg};
    assign noz_hi  = cone_hi + 16'(picvt_pkg::NOZZLE_EXTRA);

    // ---------------------------------------------------------------------
    // Stage handshake: a stage loads when empty or when its successor loads
    // ---------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    picvt_pkg::adv_t adv;

    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign adv.ld1  = rdy1;
    assign adv.ld2  = rdy2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: squares, z and y range flags, cone radius
    // ---------------------------------------------------------------------
    logic signed [C-1:0] x_in, y_in, z_in;
    assign x_in = s_tdata[C-1:0];
    assign y_in = s_tdata[2*C-1:C];
    assign z_in = s_tdata[3*C-1:2*C];

    logic signed [2*C-1:0] xsq, ysq, zsq;
    logic signed [ZW-1:0]  z_s, y_s, k_s, h_neg, cr_full;
    assign xsq = x_in * x_in;
    assign ysq = y_in * y_in;
    assign zsq = z_in * z_in;
    assign z_s = {{(ZW-C){z_in[C-1]}}, z_in};
    assign y_s = {{(ZW-C){y_in[C-1]}}, y_in};
    assign k_s = {{(ZW-15){1'b0}}, rim_k};
    assign h_neg = ZW'(0) - {{(ZW-picvt_pkg::CYLINDER_HEIGHT_W){1'b0}}, height_reg};
    assign cr_full = ZW'(picvt_pkg::CONE_LENGTH) + k_s - z_s;

    logic [2*C-1:0] xx1_reg, yy1_reg, zz1_reg;
    logic [11:0]    cr1_reg;
    logic           cyl_y1_reg, exit_z1_reg, cone_z1_reg, noz_z1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            xx1_reg     <= xsq;
            yy1_reg     <= ysq;
            zz1_reg     <= zsq;
            // cone radius fits 12 bits wherever the cone range holds
            cr1_reg     <= cr_full[11:0];
            cyl_y1_reg  <= (y_s >= h_neg) && (y_s < ZW'(0));
            exit_z1_reg <= (z_s > ZW'(0)) && (z_s <= k_s);
            cone_z1_reg <= (z_s >= k_s) && (z_s <= $signed({{(ZW-16){1'b0}}, cone_hi}));
            noz_z1_reg  <= (z_s > ZW'(0)) && (z_s <= $signed({{(ZW-16){1'b0}}, noz_hi}));
        end
    end

    // Rotation into the window frame: products in stage 1, rounding in stage 2
    logic signed [C+1:0] v2, u2;

    picvt_rotate #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rotate (
        .aclk    (aclk),
        .adv     (adv),
        .coord_x (x_in),
        .coord_z (z_in),
        .v_out   (v2),
        .u_out   (u2)
    );

    // ---------------------------------------------------------------------
    // Stage 2: sums of squares, cone radius square
    // ---------------------------------------------------------------------
    logic [SW-1:0] xx_e, yy_e, zz_e;
    assign xx_e = {{(SW-2*C){1'b0}}, xx1_reg};
    assign yy_e = {{(SW-2*C){1'b0}}, yy1_reg};
    assign zz_e = {{(SW-2*C){1'b0}}, zz1_reg};

    logic [SW-1:0]  sxyz2_reg, sxz2_reg, sxy2_reg;
    logic [23:0]    crsq2_reg;
    logic [2*C-1:0] yy2_reg;
    logic           cyl_y2_reg, exit_z2_reg, cone_z2_reg, noz_z2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            sxyz2_reg   <= xx_e + yy_e + zz_e;
            sxz2_reg    <= xx_e + zz_e;
            sxy2_reg    <= xx_e + yy_e;
            crsq2_reg   <= cr1_reg * cr1_reg;
            yy2_reg     <= yy1_reg;
            cyl_y2_reg  <= cyl_y1_reg;
            exit_z2_reg <= exit_z1_reg;
            cone_z2_reg <= cone_z1_reg;
            noz_z2_reg  <= noz_z1_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: region compares, window square, |u| against the rim
    // ---------------------------------------------------------------------
    logic signed [2*C+3:0] vsq;
    logic [C+1:0]          u_mag;
    logic [SW-1:0]         rr_e, ee_e, crsq_e;
    assign vsq    = v2 * v2;
    assign u_mag  = u2[C+1] ? (C+2)'(-u2) : u2;
    assign rr_e   = {{(SW-28){1'b0}}, rr_reg};
    assign ee_e   = {{(SW-24){1'b0}}, ee_reg};
    assign crsq_e = {{(SW-24){1'b0}}, crsq2_reg};

    logic           sphere3_reg, cyl3_reg, exit3_reg, cone3_reg, noz3_reg, uok3_reg;
    logic [2*C-1:0] vv3_reg, yy3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            sphere3_reg <= sxyz2_reg <= rr_e;
            cyl3_reg    <= cyl_y2_reg && (sxz2_reg <= rr_e);
            exit3_reg   <= exit_z2_reg && (sxy2_reg <= EXIT_SQ);
            cone3_reg   <= cone_z2_reg && (crsq_e >= sxy2_reg);
            noz3_reg    <= noz_z2_reg && (ee_e >= sxy2_reg);
            uok3_reg    <= {{(SW-C-2){1'b0}}, u_mag} <= {{(SW-15){1'b0}}, rim_k};
            vv3_reg     <= vsq[2*C-1:0];
            yy3_reg     <= yy2_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: window compare and merge into the output register
    // ---------------------------------------------------------------------
    logic [SW-1:0] win_sum;
    logic          inside4_reg;
    assign win_sum = {{(SW-2*C){1'b0}}, vv3_reg} + {{(SW-2*C){1'b0}}, yy3_reg};

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            inside4_reg <= sphere3_reg || cyl3_reg || exit3_reg || cone3_reg || noz3_reg
                           || (uok3_reg && (win_sum <= WINDOW_SQ));
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {7'b0, inside4_reg};

endmodule

// ----- design/picvt_rotate.sv -----
module picvt_rotate #(
    parameter int COORD_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  picvt_pkg::adv_t              adv,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_z,
    output logic signed [COORD_BITS+1:0] v_out,
    output logic signed [COORD_BITS+1:0] u_out
);

    localparam int PW = COORD_BITS + TRIG_FRAC_BITS + 1;
    localparam int SH = 30 - TRIG_FRAC_BITS;
    localparam longint COS_Q = (longint'(picvt_pkg::COS50_Q30) + (longint'(1) << (SH - 1))) >> SH;
    localparam longint SIN_Q = (longint'(picvt_pkg::SIN50_Q30) + (longint'(1) << (SH - 1))) >> SH;
    localparam logic signed [TRIG_FRAC_BITS:0] COS_K = (TRIG_FRAC_BITS + 1)'(COS_Q);
    localparam logic signed [TRIG_FRAC_BITS:0] SIN_K = (TRIG_FRAC_BITS + 1)'(SIN_Q);
    localparam logic signed [PW:0] HALF = (PW + 1)'(longint'(1) << (TRIG_FRAC_BITS - 1));

    logic signed [PW-1:0] cx_reg, sz_reg, sx_reg, cz_reg;
    logic signed [PW-1:0] cx_next, sz_next, sx_next, cz_next;
    logic signed [PW:0]   vq, uq;
    logic signed [COORD_BITS+1:0] v_reg, u_reg;

    assign cx_next = coord_x * COS_K;
    assign sz_next = coord_z * SIN_K;
    assign sx_next = coord_x * SIN_K;
    assign cz_next = coord_z * COS_K;

    // Round to nearest micrometre, ties toward plus infinity
    assign vq = {cx_reg[PW-1], cx_reg} - {sz_reg[PW-1], sz_reg} + HALF;
    assign uq = {sx_reg[PW-1], sx_reg} + {cz_reg[PW-1], cz_reg} + HALF;

    always_ff @(posedge aclk) begin
        if (adv.ld1) begin
            cx_reg <= cx_next;
            sz_reg <= sz_next;
            sx_reg <= sx_next;
            cz_reg <= cz_next;
        end
        if (adv.ld2) begin
            v_reg <= vq[PW:TRIG_FRAC_BITS];
            u_reg <= uq[PW:TRIG_FRAC_BITS];
        end
    end

    assign v_out = v_reg;
    assign u_out = u_reg;

endmodule

// ----- design/picvt_checker.sv -----
`include "point_in_chamber_volume_test_defines.svh"

module picvt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] m_tdata,
    input logic       m_tvalid,
    input logic       m_tready
);

    // Words in flight: accepted on the slave side, not yet taken on the master side
    logic [2:0] count_reg, count_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb begin
        count_next = count_reg;
        if (in_acc && !out_acc) count_next = count_reg + 3'd1;
        if (!in_acc && out_acc) count_next = count_reg - 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    `PICVT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped")
    `PICVT_ASSERT_IMP(a_out_pad, m_tvalid, m_tdata[7:1] == 7'd0, "pad bits set")
    `PICVT_ASSERT_IMP(a_no_phantom, m_tvalid, count_reg != 3'd0, "result without input")
    `PICVT_ASSERT_IMP(a_ready_free, count_reg < 3'd4, s_tready, "ready low with free stage")

endmodule

bind point_in_chamber_volume_test picvt_checker u_picvt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int COORD_BITS     = 16;
    localparam int TRIG_FRAC_BITS = 16;
    localparam int TRIG_SHIFT     = 30 - TRIG_FRAC_BITS;
    localparam int DATA_W         = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int CFG_W          = picvt_pkg::CFG_DATA_W;
    localparam int IDX_W          = picvt_pkg::CFG_INDEX_W;
    localparam int CLK_PERIOD     = 10;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int PIPE_SETTLE    = 6;   // exceeds the four-stage pipeline depth
    localparam int MAX_REPORTS    = 10;

    // Index past the end of the register list; writes to it must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic [DATA_W-1:0]       s_tdata   = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [7:0]              m_tdata;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]        cfg_index = '0;
    logic [CFG_W-1:0]        cfg_wdata = '0;

    // Shadow copy of the register file, as the block should hold it
    logic [picvt_pkg::CHAMBER_RADIUS_W-1:0]  radius_cfg = picvt_pkg::CHAMBER_RADIUS_RST;
    logic [picvt_pkg::CYLINDER_HEIGHT_W-1:0] height_cfg = picvt_pkg::CYLINDER_HEIGHT_RST;
    logic [picvt_pkg::EXIT_RADIUS_W-1:0]     exit_cfg   = picvt_pkg::EXIT_RADIUS_RST;

    logic [DATA_W-1:0] pending_points[$];   // words waiting for the driver
    bit                inside_expect_q[$];  // predicted inside flags, oldest first

    int points_sent     = 0;
    int results_checked = 0;
    int fail_count      = 0;
    int settings_count  = 1;
    int cycle_count     = 0;
    int hold_left       = 0;
    int next_hold_mark  = 300;
    bit steady_run      = 1'b0;   // suppress random idling on both sides

    point_in_chamber_volume_test #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),    // lowest bit up: coord_x, coord_y, coord_z
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),    // lowest bit up: inside_res
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Membership of one packed point in the union of the six regions,
    // using the shadow registers.
    function automatic bit chamber_contains(input logic [DATA_W-1:0] word);
        longint x, y, z, r, h, e, k;
        longint xx, yy, zz, rr, cr, c, s, v, u;
        bit     hit;
        x  = longint'($signed(word[COORD_BITS-1:0]));
        y  = longint'($signed(word[2*COORD_BITS-1:COORD_BITS]));
        z  = longint'($signed(word[3*COORD_BITS-1:2*COORD_BITS]));
        r  = longint'(radius_cfg);
        h  = longint'(height_cfg);
        e  = longint'(exit_cfg);
        k  = r + picvt_pkg::RIM_OFFSET;
        xx = x * x;
        yy = y * y;
        zz = z * z;
        rr = r * r;
        hit = 1'b0;
        // sphere
        if (xx + yy + zz <= rr)
            hit = 1'b1;
        // cylinder hanging below the origin
        if (y >= -h && y < 0 && xx + zz <= rr)
            hit = 1'b1;
        // exit cylinder
        if (z > 0 && z <= k && xx + yy <=
            longint'(picvt_pkg::EXIT_CYL_RADIUS) * picvt_pkg::EXIT_CYL_RADIUS)
            hit = 1'b1;
        // cone; empty range once the exit radius passes the cone length
        if (z >= k && z <= k + picvt_pkg::CONE_LENGTH - e) begin
            cr = picvt_pkg::CONE_LENGTH - (z - k);
            if (cr * cr >= xx + yy)
                hit = 1'b1;
        end
        // nozzle
        if (z > 0 && z <= k + picvt_pkg::CONE_LENGTH - e + picvt_pkg::NOZZLE_EXTRA
            && e * e >= xx + yy)
            hit = 1'b1;
        // laser window: rotate, round half up, then take |u|
        c = (longint'(picvt_pkg::COS50_Q30) + (longint'(1) << (TRIG_SHIFT - 1)))
            >>> TRIG_SHIFT;
        s = (longint'(picvt_pkg::SIN50_Q30) + (longint'(1) << (TRIG_SHIFT - 1)))
            >>> TRIG_SHIFT;
        v = (c * x - s * z + (longint'(1) << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
        u = (s * x + c * z + (longint'(1) << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
        if (u < 0)
            u = -u;
        if (u <= k && v * v + yy <=
            longint'(picvt_pkg::WINDOW_RADIUS) * picvt_pkg::WINDOW_RADIUS)
            hit = 1'b1;
        return hit;
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic queue_point(input int x, input int y, input int z);
        pending_points.push_back({z[COORD_BITS-1:0], y[COORD_BITS-1:0], x[COORD_BITS-1:0]});
    endtask

    // Mix of full-range noise, points near the chamber, and points hugging
    // the exit axis where the cone and nozzle live.
    task automatic queue_random_points(input int count);
        int span, k, roll, x, y, z;
        k    = int'(radius_cfg) + picvt_pkg::RIM_OFFSET;
        span = int'(radius_cfg) + 6000;
        if (span > 32767)
            span = 32767;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                x = $urandom();
                y = $urandom();
                z = $urandom();
            end else if (roll < 70) begin
                x = int'($urandom_range(0, 2 * span)) - span;
                y = int'($urandom_range(0, 2 * span)) - span;
                z = int'($urandom_range(0, 2 * span)) - span;
            end else begin
                x = int'($urandom_range(0, 6400)) - 3200;
                y = int'($urandom_range(0, 6400)) - 3200;
                z = int'($urandom_range(0, k + 4400)) - 200;
            end
            queue_point(x, y, z);
        end
    endtask

    // Hold until the driver is empty and every predicted word has come back,
    // then let the pipeline settle before touching the registers. Look at the
    // falling edge so the driver's updates of the rising edge have landed.
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_points.size() != 0 || s_tvalid || inside_expect_q.size() != 0)
            @(negedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        // bits past each register's width are dropped
        case (idx)
            picvt_pkg::REG_CHAMBER_RADIUS:
                radius_cfg = value[picvt_pkg::CHAMBER_RADIUS_W-1:0];
            picvt_pkg::REG_CYLINDER_HEIGHT:
                height_cfg = value[picvt_pkg::CYLINDER_HEIGHT_W-1:0];
            picvt_pkg::REG_EXIT_RADIUS:
                exit_cfg   = value[picvt_pkg::EXIT_RADIUS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input logic [CFG_W-1:0] radius,
                                input logic [CFG_W-1:0] height,
                                input logic [CFG_W-1:0] exit_r);
        write_register(picvt_pkg::REG_CHAMBER_RADIUS, radius);
        write_register(picvt_pkg::REG_CYLINDER_HEIGHT, height);
        write_register(picvt_pkg::REG_EXIT_RADIUS, exit_r);
        settings_count++;
    endtask

    // Driver: predict each word as it is taken, then offer the next one
    // unless this cycle rolls an idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                inside_expect_q.push_back(chamber_contains(s_tdata));
                points_sent <= points_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_points.size() != 0 && (steady_run || $urandom_range(0, 99) >= 16)) begin
                    s_tdata  <= pending_points.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver hold-off: every 700 results or so, count out a long stretch
    // with m_tready low so the pipeline fills and pushes back on s_tready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (results_checked >= next_hold_mark) begin
            hold_left      <= 120 + int'($urandom_range(0, 80));
            next_hold_mark <= next_hold_mark + 700;
        end
    end

    // Monitor: check each result against the oldest prediction and pick the
    // next m_tready.
    always @(posedge aclk) begin
        bit want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (inside_expect_q.size() == 0) begin
                    log_failure($sformatf("result word with nothing expected, inside_res=%0b",
                                          m_tdata[0]));
                end else begin
                    want = inside_expect_q.pop_front();
                    if (m_tdata[0] !== want)
                        log_failure($sformatf("inside_res expected %0b, got %0b",
                                              want, m_tdata[0]));
                end
                results_checked <= results_checked + 1;
            end
            if (hold_left > 0 || results_checked >= next_hold_mark) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady_run || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, inside_expect_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: R 8000, H 8000, E 750, so K = 9500.
        queue_point(0, 0, 0);
        queue_point(8000, 0, 0);             // sphere rim
        queue_point(8001, 0, 0);             // just past it
        queue_point(-32768, -32768, -32768);
        queue_point(32767, 32767, 32767);
        queue_point(-32768, 0, 0);
        queue_point(0, 32767, 0);
        queue_point(0, 0, -32768);
        queue_point(0, -8000, 100);          // cylinder floor
        queue_point(0, -8001, 0);            // below the floor
        queue_point(7000, -7999, 3000);
        queue_point(0, 0, 9500);             // top of exit cylinder
        queue_point(2999, 0, 9000);
        queue_point(3001, 0, 9000);
        queue_point(1000, 1000, 10500);      // inside the cone
        queue_point(0, 0, 11750);            // cone tip
        queue_point(0, 500, 12250);          // nozzle end
        queue_point(0, 0, 12251);            // just past the nozzle
        queue_point(-6894, 0, -5785);        // on the window axis, outside the sphere
        queue_point(-6894, 1999, -5785);
        queue_point(7278, 0, 6107);          // window end cap
        queue_point(7279, 0, 6108);
        wait_drained();

        queue_random_points(400);
        wait_drained();

        // Everything zero: regions collapse to what the inequalities allow.
        load_setting('0, '0, '0);
        queue_point(0, 0, 0);
        queue_point(1, 0, 0);
        queue_point(0, -1, 0);
        queue_point(0, 0, 1);
        queue_point(0, 0, 4501);
        queue_random_points(150);
        wait_drained();

        // All ones on the data bus: radius and exit radius lose their top bits,
        // giving R 16383, H 32767, E 4095 (above the cone length).
        load_setting({CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}});
        queue_point(0, 0, 16383);
        queue_point(0, -32767, 0);
        queue_point(0, -32768, 0);
        queue_point(0, 0, 18788);            // past the nozzle end K + 3500 - E = 17288
        queue_point(0, 0, 18789);
        queue_random_points(250);
        wait_drained();

        // Exit radius at its top legal value, and a write to the spare index
        // that must leave the registers alone.
        load_setting(15'd5000, 15'd12000, 15'd3000);
        write_register(REG_SPARE, 15'h5A5A);
        queue_point(0, 0, 6500);
        queue_point(2999, 0, 7000);
        queue_random_points(250);
        wait_drained();

        // Long stretch with no random idling on either side; the receiver hold-off still applies.
        load_setting(CFG_W'($urandom_range(0, 16383)), CFG_W'($urandom_range(0, 32767)),
                     CFG_W'($urandom_range(0, 3000)));
        steady_run = 1'b1;
        queue_random_points(400);
        wait_drained();
        steady_run = 1'b0;

        for (int p = 0; p < 3; p++) begin
            load_setting(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()));
            queue_random_points(150);
            wait_drained();
        end

        repeat (4 * PIPE_SETTLE) @(posedge aclk);
        if (inside_expect_q.size() != 0)
            log_failure($sformatf("%0d results never arrived", inside_expect_q.size()));

        $display("Checked %0d results for %0d points under %0d register settings.",
                 results_checked, points_sent, settings_count);
        $display("Coverage: all six regions, field and register extremes, masked and dropped writes.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/picvt_pkg.sv
design/picvt_rotate.sv
design/point_in_chamber_volume_test.sv
design/picvt_checker.sv
verif/tb.sv
